// ----- src/vtsd_pkg.sv -----
// vtsd_pkg: shared types and codes for the videotex screen decoder.
// Payload word structs, sequencer states, step-unit operations, byte codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vtsd_pkg;

    localparam int ROW_BITS  = 5;
    localparam int COL_BITS  = 6;
    localparam int CELL_BITS = 8;

    localparam logic [7:0] CODE_NUL   = 8'h00;
    localparam logic [7:0] CODE_BS    = 8'h08;
    localparam logic [7:0] CODE_HT    = 8'h09;
    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_VT    = 8'h0B;
    localparam logic [7:0] CODE_FF    = 8'h0C;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_CON   = 8'h11;
    localparam logic [7:0] CODE_COFF  = 8'h14;
    localparam logic [7:0] CODE_CAN   = 8'h18;
    localparam logic [7:0] CODE_ESC   = 8'h1B;
    localparam logic [7:0] CODE_RS    = 8'h1E;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_DEL   = 8'h7F;
    localparam logic [7:0] CODE_HIGH  = 8'h80;
    localparam logic [7:0] ATTR_MASK  = 8'h1F;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [7:0]          char_byte;
        logic [ROW_BITS-1:0] read_row;
        logic [COL_BITS-1:0] read_col;
    } in_t;

    typedef struct packed {
        logic [CELL_BITS-1:0] cell_data;
        logic                 read_ok;
        logic [ROW_BITS-1:0]  cursor_row;
        logic [COL_BITS-1:0]  cursor_col;
        logic                 cursor_visible;
    } out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_LINE,
        ST_WIPE,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        STEP_HOLD,
        STEP_COL_INC,
        STEP_COL_DEC,
        STEP_ROW_INC,
        STEP_ROW_DEC
    } step_op_t;

endpackage
`default_nettype wire

// ----- src/vtsd_step.sv -----
// vtsd_step: shared position step unit, one column or row move with wrap.
// Serves cursor moves and the cell sweeps. Depends on vtsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vtsd_step
    import vtsd_pkg::*;
#(
    parameter int ROWS = 24,
    parameter int COLS = 40
) (
    input  wire step_op_t            op,
    input  wire logic [ROW_BITS-1:0] row_in,
    input  wire logic [COL_BITS-1:0] col_in,
    output logic      [ROW_BITS-1:0] row_out,
    output logic      [COL_BITS-1:0] col_out
);

    localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(ROWS - 1);
    localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(COLS - 1);

    logic [ROW_BITS-1:0] row_up;
    logic [ROW_BITS-1:0] row_dn;

    assign row_up = (row_in == ROW_LAST) ? '0 : row_in + ROW_BITS'(1);
    assign row_dn = (row_in == '0) ? ROW_LAST : row_in - ROW_BITS'(1);

    always_comb begin
        row_out = row_in;
        col_out = col_in;
        case (op)
            STEP_COL_INC: begin
                if (col_in == COL_LAST) begin
                    col_out = '0;
                    row_out = row_up;
                end else begin
                    col_out = col_in + COL_BITS'(1);
                end
            end
            STEP_COL_DEC: begin
                if (col_in == '0) begin
                    col_out = COL_LAST;
                    row_out = row_dn;
                end else begin
                    col_out = col_in - COL_BITS'(1);
                end
            end
            STEP_ROW_INC: row_out = row_up;
            STEP_ROW_DEC: row_out = row_dn;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/vtsd_mem.sv -----
// vtsd_mem: screen cell store, one write and one registered read port.
// Addressed as {row, column}. Depends on vtsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vtsd_mem
    import vtsd_pkg::*;
#(
    parameter int ADDR_W = 11
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic [CELL_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output logic      [CELL_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [CELL_BITS-1:0] cells [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cells[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= cells[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- src/videotex_terminal_screen_decoder_top.sv -----
// Videotex terminal screen decoder: sequencer, cursor state and result register.
// An accepted byte or read passes through EXEC and DONE to the registered result;
// clear screen first sweeps every cell and cancel sweeps from the cursor to the
// end of its row (one cell write per cycle through the single cell store write
// port). A new word is taken only once the last result is registered. After reset
// a pass fills the store with spaces; s_ready stays low until it ends.
`timescale 1ns / 1ps
`default_nettype none
module videotex_terminal_screen_decoder_top
    import vtsd_pkg::*;
#(
    parameter int ROWS = 24,
    parameter int COLS = 40
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;

    localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(ROWS - 1);
    localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(COLS - 1);

    state_t state_reg, state_next;
    in_t    in_reg;
    logic [ROW_BITS-1:0] cur_row_reg, cur_row_next;
    logic [COL_BITS-1:0] cur_col_reg, cur_col_next;
    logic                cursor_on_reg, cursor_on_next;
    logic                esc_reg, esc_next;
    logic [ROW_BITS-1:0] sw_row_reg, sw_row_next;
    logic [COL_BITS-1:0] sw_col_reg, sw_col_next;
    logic                rd_ok_reg, rd_ok_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_reg, out_next;

    step_op_t            step_op;
    logic [ROW_BITS-1:0] step_row_in, step_row_out;
    logic [COL_BITS-1:0] step_col_in, step_col_out;

    logic                 wr_en, rd_en;
    logic [ROW_BITS-1:0]  wr_row;
    logic [COL_BITS-1:0]  wr_col;
    logic [CELL_BITS-1:0] wr_data, rd_data;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic                 sweeping;
    logic [7:0]           b;

    assign sweeping    = (state_reg == ST_INIT) || (state_reg == ST_WIPE) ||
                         (state_reg == ST_LINE);
    assign step_row_in = sweeping ? sw_row_reg : cur_row_reg;
    assign step_col_in = sweeping ? sw_col_reg : cur_col_reg;
    assign wr_addr     = {wr_row[ROW_W-1:0], wr_col[COL_W-1:0]};
    assign rd_addr     = {in_reg.read_row[ROW_W-1:0], in_reg.read_col[COL_W-1:0]};
    assign b           = in_reg.char_byte;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    vtsd_step #(.ROWS(ROWS), .COLS(COLS)) u_step (
        .op      (step_op),
        .row_in  (step_row_in),
        .col_in  (step_col_in),
        .row_out (step_row_out),
        .col_out (step_col_out)
    );

    vtsd_mem #(.ADDR_W(ADDR_W)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cursor_on_reg <= 1'b1;
            esc_reg       <= 1'b0;
            sw_row_reg    <= '0;
            sw_col_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cursor_on_reg <= cursor_on_next;
            esc_reg       <= esc_next;
            sw_row_reg    <= sw_row_next;
            sw_col_reg    <= sw_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        rd_ok_reg <= rd_ok_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cursor_on_next = cursor_on_reg;
        esc_next       = esc_reg;
        sw_row_next    = sw_row_reg;
        sw_col_next    = sw_col_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        step_op        = STEP_HOLD;
        wr_en          = 1'b0;
        wr_row         = cur_row_reg;
        wr_col         = cur_col_reg;
        wr_data        = CODE_SPACE;
        rd_en          = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT, ST_WIPE, ST_LINE: begin
                wr_en       = 1'b1;
                wr_row      = sw_row_reg;
                wr_col      = sw_col_reg;
                step_op     = STEP_COL_INC;
                sw_row_next = step_row_out;
                sw_col_next = step_col_out;
                if (sw_col_reg == COL_LAST &&
                    (state_reg == ST_LINE || sw_row_reg == ROW_LAST)) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                if (in_reg.req_type == REQ_READ) begin
                    rd_en      = 1'b1;
                    rd_ok_next = ({1'b0, in_reg.read_row} < (ROW_BITS + 1)'(ROWS)) &&
                                 ({1'b0, in_reg.read_col} < (COL_BITS + 1)'(COLS));
                end else begin
                    rd_ok_next = 1'b0;
                    if (b == CODE_NUL) begin
                        esc_next = esc_reg;
                    end else if (b == CODE_ESC) begin
                        esc_next = 1'b1;
                    end else if (esc_reg || b >= CODE_HIGH) begin
                        esc_next     = 1'b0;
                        wr_en        = 1'b1;
                        wr_data      = b & ATTR_MASK;
                        step_op      = STEP_COL_INC;
                        cur_row_next = step_row_out;
                        cur_col_next = step_col_out;
                    end else begin
                        case (b)
                            CODE_BS: step_op = STEP_COL_DEC;
                            CODE_HT: step_op = STEP_COL_INC;
                            CODE_LF: step_op = STEP_ROW_INC;
                            CODE_VT: step_op = STEP_ROW_DEC;
                            CODE_FF: begin
                                sw_row_next = '0;
                                sw_col_next = '0;
                                state_next  = ST_WIPE;
                            end
                            CODE_CAN: begin
                                sw_row_next = cur_row_reg;
                                sw_col_next = cur_col_reg;
                                state_next  = ST_LINE;
                            end
                            CODE_CON:  cursor_on_next = 1'b1;
                            CODE_COFF: cursor_on_next = 1'b0;
                            default: begin
                                if (b inside {[CODE_SPACE:CODE_DEL]}) begin
                                    wr_en   = 1'b1;
                                    wr_data = b;
                                    step_op = STEP_COL_INC;
                                end
                            end
                        endcase
                        cur_row_next = step_row_out;
                        cur_col_next = step_col_out;
                        if (b == CODE_FF || b == CODE_RS) begin
                            cur_row_next = '0;
                            cur_col_next = '0;
                        end else if (b == CODE_CR) begin
                            cur_col_next = '0;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next          = 1'b1;
                    out_next.cell_data      = rd_ok_reg ? rd_data : '0;
                    out_next.read_ok        = rd_ok_reg;
                    out_next.cursor_row     = cur_row_reg;
                    out_next.cursor_col     = cur_col_reg;
                    out_next.cursor_visible = cursor_on_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/vtsd_checker.sv -----
// vtsd_checker: port-level assertions for the videotex screen decoder,
// bound to the top level. Depends on vtsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vtsd_checker
    import vtsd_pkg::*;
#(
    parameter int ROWS = 24,
    parameter int COLS = 40
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_bad_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.read_ok |-> m_data.cell_data == '0)
        else $error("cell data without a valid read");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.cursor_row} < (ROW_BITS + 1)'(ROWS)) &&
                    ({1'b0, m_data.cursor_col} < (COL_BITS + 1)'(COLS)))
        else $error("cursor outside the screen");

    a_fill_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during the fill pass");

    a_one_word: assert property (@(posedge aclk)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while busy");

endmodule

bind videotex_terminal_screen_decoder_top vtsd_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
) u_vtsd_checker (.*);
`default_nettype wire

// ----- tb/videotex_terminal_screen_decoder_top_tb.sv -----
// Self-checking testbench for videotex_terminal_screen_decoder_top: directed table, then
// random byte and cell-read words, each result checked against its typed table word
// or a behavioral screen model. Depends on vtsd_pkg and the decoder top level only.
`timescale 1ns / 1ps
module videotex_terminal_screen_decoder_top_tb;
    import vtsd_pkg::*;

    localparam int ROWS_N      = 24;
    localparam int COLS_N      = 40;
    localparam int RANDOM_WORDS = 1700;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 50;
    localparam int LONG_HOLD   = 500;
    localparam int HOLD_AT     = 300;
    localparam logic [7:0] CODE_SOH = 8'h01;

    typedef struct packed {
        in_t  word;
        logic typed;
        out_t result;
    } stim_row_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    videotex_terminal_screen_decoder_top #(
        .ROWS(ROWS_N),
        .COLS(COLS_N)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // screen model state
    logic [7:0] shadow_screen [ROWS_N*COLS_N];
    logic [4:0] shadow_row;
    logic [5:0] shadow_col;
    logic       shadow_cursor_on;
    logic       shadow_esc;

    out_t expected_results[$];
    int   error_count = 0;
    int   results_seen = 0;
    int   cycle_count = 0;
    int   ready_stall = 0;
    bit   long_hold_done = 0;
    bit   calm = 0;

    stim_row_t directed_rows [26] = '{
        {REQ_READ, 8'h00,      5'd0,  6'd0,  1'b1, 8'h20, 1'b1, 5'd0,  6'd0,  1'b1},
        {REQ_READ, 8'hFF,      5'd23, 6'd39, 1'b1, 8'h20, 1'b1, 5'd0,  6'd0,  1'b1},
        {REQ_READ, 8'h00,      5'd24, 6'd0,  1'b1, 8'h00, 1'b0, 5'd0,  6'd0,  1'b1},
        {REQ_READ, 8'h00,      5'd31, 6'd63, 1'b1, 8'h00, 1'b0, 5'd0,  6'd0,  1'b1},
        {REQ_BYTE, CODE_BS,    5'd0,  6'd0,  1'b1, 8'h00, 1'b0, 5'd23, 6'd39, 1'b1},
        {REQ_BYTE, CODE_HT,    5'd31, 6'd63, 1'b1, 8'h00, 1'b0, 5'd0,  6'd0,  1'b1},
        {REQ_BYTE, CODE_VT,    5'd0,  6'd0,  1'b1, 8'h00, 1'b0, 5'd23, 6'd0,  1'b1},
        {REQ_BYTE, CODE_LF,    5'd31, 6'd63, 1'b1, 8'h00, 1'b0, 5'd0,  6'd0,  1'b1},
        {REQ_BYTE, 8'h41,      5'd31, 6'd63, 1'b0, 21'd0},
        {REQ_BYTE, CODE_DEL,   5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, 8'hFF,      5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_HIGH,  5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_ESC,   5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_ESC,   5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_NUL,   5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, 8'h41,      5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_COFF,  5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_SOH,   5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_CAN,   5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_CR,    5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_HT,    5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_RS,    5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_BYTE, CODE_CON,   5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_READ, 8'h00,      5'd0,  6'd4,  1'b0, 21'd0},
        {REQ_BYTE, CODE_FF,    5'd0,  6'd0,  1'b0, 21'd0},
        {REQ_READ, 8'h00,      5'd0,  6'd2,  1'b0, 21'd0}
    };

    function automatic void shift_cursor(int drow, int dcol);
        int nr;
        int nc;
        nr = int'(shadow_row) + drow;
        nc = int'(shadow_col) + dcol;
        if (nc < 0) begin
            nc = COLS_N - 1;
            nr = nr - 1;
        end
        if (nc >= COLS_N) begin
            nc = 0;
            nr = nr + 1;
        end
        if (nr < 0) nr = ROWS_N - 1;
        if (nr >= ROWS_N) nr = 0;
        shadow_row = 5'(nr);
        shadow_col = 6'(nc);
    endfunction

    function automatic void place_code(logic [7:0] code);
        shadow_screen[int'(shadow_row) * COLS_N + int'(shadow_col)] = code;
        shift_cursor(0, 1);
    endfunction

    function automatic void wipe_screen();
        for (int i = 0; i < ROWS_N * COLS_N; i++) shadow_screen[i] = CODE_SPACE;
        shadow_row = '0;
        shadow_col = '0;
    endfunction

    function automatic void apply_byte(logic [7:0] b);
        if (b == CODE_NUL) return;
        if (b == CODE_ESC) begin
            shadow_esc = 1'b1;
            return;
        end
        if (shadow_esc || b >= CODE_HIGH) begin
            shadow_esc = 1'b0;
            place_code(b & ATTR_MASK);
            return;
        end
        case (b)
            CODE_BS: shift_cursor(0, -1);
            CODE_HT: shift_cursor(0, 1);
            CODE_LF: shift_cursor(1, 0);
            CODE_VT: shift_cursor(-1, 0);
            CODE_FF: wipe_screen();
            CODE_CR: shadow_col = '0;
            CODE_CON: shadow_cursor_on = 1'b1;
            CODE_COFF: shadow_cursor_on = 1'b0;
            CODE_CAN: begin
                for (int x = int'(shadow_col); x < COLS_N; x++)
                    shadow_screen[int'(shadow_row) * COLS_N + x] = CODE_SPACE;
            end
            CODE_RS: begin
                shadow_row = '0;
                shadow_col = '0;
            end
            default: if (b >= CODE_SPACE) place_code(b);
        endcase
    endfunction

    function automatic out_t predict_screen_word(in_t w);
        out_t r;
        r = '0;
        if (w.req_type == REQ_BYTE) begin
            apply_byte(w.char_byte);
        end else if (int'(w.read_row) < ROWS_N && int'(w.read_col) < COLS_N) begin
            r.cell_data = shadow_screen[int'(w.read_row) * COLS_N + int'(w.read_col)];
            r.read_ok   = 1'b1;
        end
        r.cursor_row     = shadow_row;
        r.cursor_col     = shadow_col;
        r.cursor_visible = shadow_cursor_on;
        return r;
    endfunction

    // mostly short gaps, a few long ones, none during the calm stretch
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_t random_word();
        in_t w;
        int  pick;
        w.req_type  = REQ_BYTE;
        w.char_byte = 8'($urandom_range(0, 255));
        w.read_row  = 5'($urandom_range(0, 31));
        w.read_col  = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            w.req_type = REQ_READ;
            if ($urandom_range(0, 9) != 0) begin
                w.read_row = 5'($urandom_range(0, ROWS_N - 1));
                w.read_col = 6'($urandom_range(0, COLS_N - 1));
            end
        end else if (pick < 58) begin
            w.char_byte = 8'($urandom_range(CODE_SPACE, CODE_DEL));
        end else if (pick < 66) begin
            w.char_byte = 8'($urandom_range(CODE_HIGH, 8'hFF));
        end else if (pick < 72) begin
            w.char_byte = CODE_ESC;
        end else if (pick < 89) begin
            case ($urandom_range(0, 8))
                0: w.char_byte = CODE_BS;
                1: w.char_byte = CODE_HT;
                2: w.char_byte = CODE_LF;
                3: w.char_byte = CODE_VT;
                4: w.char_byte = CODE_CR;
                5: w.char_byte = CODE_CON;
                6: w.char_byte = CODE_COFF;
                7: w.char_byte = CODE_CAN;
                default: w.char_byte = CODE_RS;
            endcase
        end else if (pick < 90) begin
            w.char_byte = CODE_FF;
        end else if (pick < 96) begin
            w.char_byte = 8'($urandom_range(0, CODE_SPACE - 1));
        end
        return w;
    endfunction

    task automatic send_word(in_t w, bit use_typed, out_t typed_result);
        int   gap;
        out_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_screen_word(w);
        expected_results.push_back(use_typed ? typed_result : predicted);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check, then decide ready for the next edge
    always @(posedge aclk) begin
        out_t want;
        if (m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", 32'(m_data), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.cell_data !== want.cell_data)
                    report_mismatch("cell_data", 32'(m_data.cell_data), 32'(want.cell_data));
                if (m_data.read_ok !== want.read_ok)
                    report_mismatch("read_ok", 32'(m_data.read_ok), 32'(want.read_ok));
                if (m_data.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", 32'(m_data.cursor_row), 32'(want.cursor_row));
                if (m_data.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", 32'(m_data.cursor_col), 32'(want.cursor_col));
                if (m_data.cursor_visible !== want.cursor_visible)
                    report_mismatch("cursor_visible", 32'(m_data.cursor_visible),
                                    32'(want.cursor_visible));
            end
        end
        if (!long_hold_done && results_seen >= HOLD_AT) begin
            ready_stall    = LONG_HOLD;
            long_hold_done = 1;
        end
        if (ready_stall > 0) begin
            m_ready <= 1'b0;
            ready_stall--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_stall = pick_gap();
        end
    end

    initial begin
        wipe_screen();
        shadow_cursor_on = 1'b1;
        shadow_esc       = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 800 && n < 1000);
            send_word(random_word(), 1'b0, '0);
        end
        calm = 0;
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/vtsd_pkg.sv
src/vtsd_step.sv
src/vtsd_mem.sv
src/videotex_terminal_screen_decoder_top.sv
src/vtsd_checker.sv
tb/videotex_terminal_screen_decoder_top_tb.sv
